// File: design/long_to_short_filename_top_defines.svh
// Assertion macros shared by the short-name generator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef LONG_TO_SHORT_FILENAME_TOP_DEFINES_SVH
`define LONG_TO_SHORT_FILENAME_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LFSN_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LFSN_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lfsn_pkg.sv
// Package for the short-name generator: character constants, the job record
// passed from the front end to the back end, and the case-folding function.
`default_nettype none

package lfsn_pkg;

	localparam int BASE_LEN   = 8;
	localparam int EXT_LEN    = 3;
	localparam int NAME_LEN   = BASE_LEN + EXT_LEN;
	localparam int JOBQ_DEPTH = 2;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_TILDE = 8'h7E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
	localparam logic [7:0] CASE_DIFF  = 8'd32;

	// Tails from 1 up to one below this limit are applied.
	localparam logic [15:0] TAIL_LIMIT = 16'd9999;

	// Division by ten as a multiply by 2^19/10 rounded up, exact below 43699.
	localparam logic [15:0] RECIP_TEN   = 16'd52429;
	localparam int          RECIP_SHIFT = 19;

	// One finished name as collected by the front end.
	typedef struct packed {
		logic [NAME_LEN-1:0][7:0] bytes;
		logic                     lead_dot;
		logic                     tail_ok;
		logic [13:0]              tail;
	} job_t;

	// Lower-case a..z becomes upper case; everything else passes unchanged.
	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
			r = c - CASE_DIFF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/lfsn_front.sv
// Front end: takes one long-name character per cycle while in_take is high
// and collects base and extension bytes. Depends on lfsn_pkg; feeds lfsn_jobq.
`default_nettype none

module lfsn_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_take,
	input  wire logic [7:0]    name_char,
	input  wire logic          name_last,
	input  wire logic [15:0]   tail_number,
	output logic               job_push,
	output lfsn_pkg::job_t     job_data
);
	import lfsn_pkg::*;

	logic [BASE_LEN-1:0][7:0] base_q, base_n;
	logic [EXT_LEN-1:0][7:0]  ext_q, ext_n;
	logic [3:0]               bcnt_q, bcnt_n;
	logic [1:0]               ecnt_q, ecnt_n;
	logic                     dot_q, dot_n;
	logic                     first_q;
	logic                     lead_q, lead_n;
	logic [7:0]               up_char;

	// Next collection state with the current character folded in.
	always_comb begin
		up_char = to_upper(name_char);
		base_n  = base_q;
		ext_n   = ext_q;
		bcnt_n  = bcnt_q;
		ecnt_n  = ecnt_q;
		dot_n   = dot_q;
		lead_n  = lead_q || (first_q && (name_char == CHAR_DOT));
		if (!dot_q) begin
			if (name_char == CHAR_DOT) begin
				dot_n = 1'b1;
			end else if ((name_char != CHAR_SPACE) && !bcnt_q[3]) begin
				base_n[bcnt_q[2:0]] = up_char;
				bcnt_n              = bcnt_q + 4'd1;
			end
		end else if (ecnt_q != 2'(EXT_LEN)) begin
			ext_n[ecnt_q] = up_char;
			ecnt_n        = ecnt_q + 2'd1;
		end
	end

	// The final character hands the whole name on as one job.
	always_comb begin
		job_push          = in_take && name_last;
		job_data.bytes    = {ext_n, base_n};
		job_data.lead_dot = lead_n;
		job_data.tail_ok  = (tail_number != 16'd0) && (tail_number < TAIL_LIMIT);
		job_data.tail     = tail_number[13:0];
	end

	// Collection state; it returns to empty after each final character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= {BASE_LEN{CHAR_SPACE}};
			ext_q   <= {EXT_LEN{CHAR_SPACE}};
			bcnt_q  <= '0;
			ecnt_q  <= '0;
			dot_q   <= 1'b0;
			first_q <= 1'b1;
			lead_q  <= 1'b0;
		end else if (in_take) begin
			if (name_last) begin
				base_q  <= {BASE_LEN{CHAR_SPACE}};
				ext_q   <= {EXT_LEN{CHAR_SPACE}};
				bcnt_q  <= '0;
				ecnt_q  <= '0;
				dot_q   <= 1'b0;
				first_q <= 1'b1;
				lead_q  <= 1'b0;
			end else begin
				base_q  <= base_n;
				ext_q   <= ext_n;
				bcnt_q  <= bcnt_n;
				ecnt_q  <= ecnt_n;
				dot_q   <= dot_n;
				first_q <= 1'b0;
				lead_q  <= lead_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/lfsn_jobq.sv
// Two-entry queue of finished names between the front end and the back end.
// Depends on lfsn_pkg for the job record and depth.
`default_nettype none

`include "long_to_short_filename_top_defines.svh"

module lfsn_jobq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  lfsn_pkg::job_t     push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               job_valid,
	output lfsn_pkg::job_t     job_data
);
	import lfsn_pkg::*;

	job_t       mem_q [JOBQ_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'(JOBQ_DEPTH));
	assign job_valid = (count_q != 2'd0);
	assign job_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && job_valid;

	// Entry storage; no reset needed on the payload.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`LFSN_ASSERT_NOW(a_jobq_count, clk, arst_n, 1'b1, count_q <= 2'(JOBQ_DEPTH), "job queue count exceeds its depth")

endmodule

`default_nettype wire

// File: design/lfsn_back.sv
// Back end: writes a valid numeric tail in decimal, one digit per cycle, then
// sends the 11 short-name words, or one word for a leading dot, out through a
// registered output stage. Depends on lfsn_pkg; takes jobs from lfsn_jobq.
`default_nettype none

`include "long_to_short_filename_top_defines.svh"

module lfsn_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  lfsn_pkg::job_t     job_data,
	output logic               job_pop,
	output logic [7:0]         short_char,
	output logic               short_last,
	output logic               status,
	output logic               empty,
	input  wire logic          pop
);
	import lfsn_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

	state_t                   state_q;
	logic [NAME_LEN-1:0][7:0] name_q;
	logic                     lead_q;
	logic                     tail_ok_q;
	logic [2:0]               ndig_q;
	logic [3:0]               dig_q [4];
	logic [13:0]              val_q;
	logic [1:0]               step_q;
	logic [3:0]               idx_q;
	logic                     out_valid_q;
	logic [7:0]               out_char_q;
	logic                     out_last_q;
	logic                     out_status_q;

	logic [29:0] prod;
	logic [10:0] quo;
	logic [13:0] rem;
	logic [3:0]  tilde_pos;
	logic [3:0]  rel;
	logic [7:0]  emit_byte;
	logic        emit_last;
	logic        can_load;
	logic [2:0]  ndig_new;

	assign job_pop    = (state_q == ST_IDLE) && job_valid;
	assign can_load   = !out_valid_q || pop;
	assign empty      = !out_valid_q;
	assign short_char = out_char_q;
	assign short_last = out_last_q;
	assign status     = out_status_q;

	// Digit count of the tail, taken when a job is loaded.
	always_comb begin
		if (job_data.tail < 14'd10) begin
			ndig_new = 3'd1;
		end else if (job_data.tail < 14'd100) begin
			ndig_new = 3'd2;
		end else if (job_data.tail < 14'd1000) begin
			ndig_new = 3'd3;
		end else begin
			ndig_new = 3'd4;
		end
	end

	// One decimal digit per cycle: quotient by reciprocal, remainder by subtract.
	always_comb begin
		prod = 30'(val_q) * 30'(RECIP_TEN);
		quo  = prod[29:RECIP_SHIFT];
		rem  = val_q - (14'(quo) * 14'd10);
	end

	// Selects the word at the current index, with the tail laid over the base.
	always_comb begin
		tilde_pos = 4'd7 - {1'b0, ndig_q};
		rel       = 4'd7 - idx_q;
		emit_byte = name_q[idx_q];
		if (tail_ok_q && (idx_q < 4'(BASE_LEN))) begin
			if (idx_q == tilde_pos) begin
				emit_byte = CHAR_TILDE;
			end else if (idx_q > tilde_pos) begin
				emit_byte = CHAR_ZERO + {4'b0000, dig_q[rel[1:0]]};
			end
		end
		if (lead_q) begin
			emit_byte = 8'h00;
		end
		emit_last = lead_q || (idx_q == 4'(NAME_LEN - 1));
	end

	// Sequencer with its working registers and the output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			idx_q       <= '0;
		end else begin
			// The output word is replaced by a new one or emptied by a pop.
			if ((state_q == ST_EMIT) && can_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						name_q    <= job_data.bytes;
						lead_q    <= job_data.lead_dot;
						tail_ok_q <= job_data.tail_ok;
						val_q     <= job_data.tail;
						ndig_q    <= ndig_new;
						step_q    <= '0;
						idx_q     <= '0;
						if (job_data.tail_ok && !job_data.lead_dot) begin
							state_q <= ST_CONV;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_CONV: begin
					dig_q[step_q] <= rem[3:0];
					val_q         <= 14'(quo);
					step_q        <= step_q + 2'd1;
					if ({1'b0, step_q} == (ndig_q - 3'd1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (can_load) begin
						out_char_q   <= emit_byte;
						out_last_q   <= emit_last;
						out_status_q <= lead_q;
						idx_q        <= idx_q + 4'd1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LFSN_ASSERT_NOW(a_lead_single, clk, arst_n, out_valid_q && out_status_q, out_last_q && (out_char_q == 8'h00), "invalid-name result must be one zero word")
	`LFSN_ASSERT_NEXT(a_burst_gapless, clk, arst_n, out_valid_q && pop && !out_last_q, out_valid_q, "gap inside a short-name burst")

endmodule

`default_nettype wire

// File: design/long_to_short_filename_top.sv
// 8.3 short-name generator. The input side takes one long-name character per
// cycle (push while full is low). Finished names wait in a two-entry queue in
// front of the back end; full is high while both entries hold names that the
// busy back end has not yet taken, and then no character is accepted at all.
// Each name comes out as 11 words (base bytes, then extension bytes), or as one
// status word for a name that starts with a dot. Without output stalls the back
// end loads a name, writes one tail digit per cycle (up to four) and then sends
// one output word per cycle; for short names this back-end work, not the input
// port, sets the sustained rate. Depends on lfsn_pkg and the sub-blocks.
`default_nettype none

module long_to_short_filename_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  name_char,
	input  wire logic        name_last,
	input  wire logic [15:0] tail_number,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       short_char,
	output logic             short_last,
	output logic             status
);
	import lfsn_pkg::*;

	logic in_take;
	logic job_push;
	job_t job_in;
	logic job_valid;
	job_t job_out;
	logic job_pop;

	assign in_take = push && !full;

	// Character collection.
	lfsn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_take     (in_take),
		.name_char   (name_char),
		.name_last   (name_last),
		.tail_number (tail_number),
		.job_push    (job_push),
		.job_data    (job_in)
	);

	// Finished names waiting for the back end.
	lfsn_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (full),
		.pop       (job_pop),
		.job_valid (job_valid),
		.job_data  (job_out)
	);

	// Tail conversion and word output.
	lfsn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job_data   (job_out),
		.job_pop    (job_pop),
		.short_char (short_char),
		.short_last (short_last),
		.status     (status),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

`default_nettype wire
